// ===== rtl/pcms_pkg.sv =====
// Package with shared stage types and constants for the sample-to-PCM converter.
package pcms_pkg;

  localparam int unsigned RawW   = 64;
  localparam int unsigned PcmW   = 16;
  localparam int unsigned FmtW   = 2;
  localparam int unsigned MantW  = 53;
  localparam int unsigned ProdW  = 68;
  localparam int unsigned RndW   = 54;
  localparam int unsigned ShW    = 7;

  typedef enum logic [FmtW-1:0] {
    FMT_INT16 = 2'd0,
    FMT_INT32 = 2'd1,
    FMT_FLT32 = 2'd2,
    FMT_FLT64 = 2'd3
  } fmt_t;

  localparam logic [PcmW-1:0] PcmPosFull = 16'h7FFF;
  localparam logic [PcmW-1:0] PcmNegFull = 16'h8001;

  typedef struct packed {
    logic             direct;
    logic [PcmW-1:0]  dir_val;
    logic             neg;
    logic             dbl;
    logic [MantW-1:0] mant;
    logic [ShW-1:0]   sh;
  } dec_t;

  typedef struct packed {
    logic             direct;
    logic [PcmW-1:0]  dir_val;
    logic             neg;
    logic             dbl;
    logic [ProdW-1:0] prod;
    logic [ShW-1:0]   sh;
  } mul_t;

  typedef struct packed {
    logic             direct;
    logic [PcmW-1:0]  dir_val;
    logic             neg;
    logic [RndW-1:0]  rnd;
    logic [ShW-1:0]   sh;
  } rnd_t;

endpackage

// ===== rtl/pcms_if.sv =====
// Channel interfaces for the input, result and configuration ports.
interface pcms_in_if;
  logic                          valid;
  logic                          ready;
  logic [pcms_pkg::RawW-1:0]     raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface pcms_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pcms_pkg::PcmW-1:0] pcm_out;
  modport source (output valid, output pcm_out, input ready);
  modport sink (input valid, input pcm_out, output ready);
endinterface

interface pcms_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [pcms_pkg::FmtW-1:0]     source_format;
  modport source (output valid, output source_format, input ready);
  modport sink (input valid, input source_format, output ready);
endinterface

// ===== rtl/pcm_sample_to_s16_converter.sv =====
// Top level of the sample-to-PCM converter: config register and four-stage pipeline.
// The block converts one raw sample word to a signed 16-bit PCM sample.
// The in channel carries the raw sample, right aligned; the out channel
// carries the converted sample. Both use a valid/ready handshake.
// The cfg channel writes the source format (int16, int32, float, double);
// it is always ready and must be written only while the pipeline is empty.
// Each item passes four register stages: decode, multiply by 32767,
// rounding to source precision, and shift with sign; the shift stage
// register drives the out channel.
// One item is accepted per cycle as long as the out channel takes results.
// When the receiver stalls with the output stage full, the whole pipeline
// holds, and the in channel stays ready only while the output stage is empty.
// Reset clears all valid bits and sets the source format to int16.
module pcm_sample_to_s16_converter (
  input  logic       clk,
  input  logic       rst_n,
  pcms_in_if.sink    in_ch,
  pcms_out_if.source out_ch,
  pcms_cfg_if.sink   cfg_ch
);

  pcms_pkg::fmt_t fmt_r;
  logic           adv;
  logic           v1;
  logic           v2;
  logic           v3;
  logic           v4;
  pcms_pkg::dec_t dec;
  pcms_pkg::mul_t mul;
  pcms_pkg::rnd_t rnd;
  logic [pcms_pkg::PcmW-1:0] pcm;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= pcms_pkg::FMT_INT16;
    end else if (cfg_ch.valid) begin
      fmt_r <= pcms_pkg::fmt_t'(cfg_ch.source_format);
    end
  end

  assign adv         = !v4 || out_ch.ready;
  assign in_ch.ready = adv;

  pcms_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_ch.valid),
    .raw      (in_ch.raw_sample),
    .fmt      (fmt_r),
    .valid_r  (v1),
    .dec_r    (dec)
  );

  pcms_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v1),
    .dec      (dec),
    .valid_r  (v2),
    .mul_r    (mul)
  );

  pcms_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v2),
    .mul      (mul),
    .valid_r  (v3),
    .rnd_r    (rnd)
  );

  pcms_shift u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (v3),
    .rnd      (rnd),
    .valid_r  (v4),
    .pcm_r    (pcm)
  );

  assign out_ch.valid   = v4;
  assign out_ch.pcm_out = pcm;

endmodule

// ===== rtl/pcms_decode.sv =====
// First stage: format decode, clamping, special values and mantissa extraction.
module pcms_decode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [pcms_pkg::RawW-1:0]  raw,
  input  pcms_pkg::fmt_t             fmt,
  output logic                       valid_r,
  output pcms_pkg::dec_t             dec_r
);

  pcms_pkg::dec_t dec_nxt;
  logic [7:0]     fex;
  logic [10:0]    dex;
  logic [22:0]    ffr;
  logic [51:0]    dfr;

  always_comb begin
    fex = raw[30:23];
    ffr = raw[22:0];
    dex = raw[62:52];
    dfr = raw[51:0];
    dec_nxt = '0;
    unique case (fmt)
      pcms_pkg::FMT_INT16: begin
        dec_nxt.direct  = 1'b1;
        dec_nxt.dir_val = raw[15:0];
      end
      pcms_pkg::FMT_INT32: begin
        dec_nxt.direct  = 1'b1;
        dec_nxt.dir_val = raw[31:16];
      end
      pcms_pkg::FMT_FLT32: begin
        dec_nxt.neg = raw[31];
        if (fex == 8'd255 && ffr != '0) begin
          dec_nxt.direct  = 1'b1;
          dec_nxt.dir_val = pcms_pkg::PcmPosFull;
        end else if (fex >= 8'd127) begin
          dec_nxt.direct  = 1'b1;
          dec_nxt.dir_val = raw[31] ? pcms_pkg::PcmNegFull : pcms_pkg::PcmPosFull;
        end else if (fex < 8'd111) begin
          dec_nxt.direct  = 1'b1;
          dec_nxt.dir_val = '0;
        end else begin
          dec_nxt.mant = {29'd0, 1'b1, ffr};
          dec_nxt.sh   = 7'(8'd150 - fex);
        end
      end
      default: begin
        dec_nxt.neg = raw[63];
        dec_nxt.dbl = 1'b1;
        if (dex == 11'd2047 && dfr != '0) begin
          dec_nxt.direct  = 1'b1;
          dec_nxt.dir_val = pcms_pkg::PcmPosFull;
        end else if (dex >= 11'd1023) begin
          dec_nxt.direct  = 1'b1;
          dec_nxt.dir_val = raw[63] ? pcms_pkg::PcmNegFull : pcms_pkg::PcmPosFull;
        end else if (dex < 11'd1007) begin
          dec_nxt.direct  = 1'b1;
          dec_nxt.dir_val = '0;
        end else begin
          dec_nxt.mant = {1'b1, dfr};
          dec_nxt.sh   = 7'(11'd1075 - dex);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

// ===== rtl/pcms_scale.sv =====
// Second stage: exact product of the mantissa with 32767.
module pcms_scale (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pcms_pkg::dec_t dec,
  output logic           valid_r,
  output pcms_pkg::mul_t mul_r
);

  pcms_pkg::mul_t mul_nxt;

  always_comb begin
    mul_nxt.direct  = dec.direct;
    mul_nxt.dir_val = dec.dir_val;
    mul_nxt.neg     = dec.neg;
    mul_nxt.dbl     = dec.dbl;
    mul_nxt.sh      = dec.sh;
    mul_nxt.prod    = {dec.mant, 15'd0} - {15'd0, dec.mant};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r <= mul_nxt;
    end
  end

endmodule

// ===== rtl/pcms_round.sv =====
// Third stage: rounds the product to source precision, nearest even.
module pcms_round (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  pcms_pkg::mul_t mul,
  output logic           valid_r,
  output pcms_pkg::rnd_t rnd_r
);

  pcms_pkg::rnd_t         rnd_nxt;
  logic                   hi;
  logic                   lsb;
  logic                   grd;
  logic                   stk;
  logic [pcms_pkg::RndW-1:0] kept;

  always_comb begin
    hi = mul.dbl ? mul.prod[67] : mul.prod[38];
    if (hi) begin
      kept = {1'b0, mul.prod[67:15]};
      lsb  = mul.prod[15];
      grd  = mul.prod[14];
      stk  = |mul.prod[13:0];
    end else begin
      kept = mul.prod[67:14];
      lsb  = mul.prod[14];
      grd  = mul.prod[13];
      stk  = |mul.prod[12:0];
    end
    rnd_nxt.direct  = mul.direct;
    rnd_nxt.dir_val = mul.dir_val;
    rnd_nxt.neg     = mul.neg;
    rnd_nxt.rnd     = kept + {53'd0, grd & (stk | lsb)};
    rnd_nxt.sh      = mul.sh - (hi ? 7'd15 : 7'd14);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r <= rnd_nxt;
    end
  end

endmodule

// ===== rtl/pcms_shift.sv =====
// Fourth stage: truncating shift, sign and output register.
module pcms_shift (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  pcms_pkg::rnd_t                rnd,
  output logic                          valid_r,
  output logic [pcms_pkg::PcmW-1:0]     pcm_r
);

  logic [pcms_pkg::RndW-1:0] shifted;
  logic [pcms_pkg::PcmW-1:0] mag;
  logic [pcms_pkg::PcmW-1:0] pcm_nxt;

  always_comb begin
    shifted = rnd.rnd >> rnd.sh;
    mag     = shifted[pcms_pkg::PcmW-1:0];
    if (rnd.direct) begin
      pcm_nxt = rnd.dir_val;
    end else begin
      pcm_nxt = rnd.neg ? (~mag + 16'd1) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pcm_r <= pcm_nxt;
    end
  end

endmodule
